// ----- rtl/rrpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin PRB allocator package
// Widths, limits, register indexes and the command and status structures
// shared by the allocator's controller and datapath.
// ----------------------------------------------------------------------------
package rrpa_pkg;

   localparam int TICK_WIDTH      = 16;
   localparam int USER_WIDTH      = 7;
   localparam int BLOCK_WIDTH     = 10;
   localparam int SLOT_WIDTH      = 6;
   localparam int START_WIDTH     = 9;
   localparam int LENGTH_WIDTH    = 10;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 10;
   localparam int DIV_STEPS       = BLOCK_WIDTH;
   localparam int DIV_COUNT_WIDTH = 4;

   localparam logic [USER_WIDTH-1:0]  MAX_USERS  = 7'd64;
   localparam logic [BLOCK_WIDTH-1:0] MAX_BLOCKS = 10'd512;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_USER_COUNT  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_COUNT = 1'b1;

   typedef struct packed {
      logic load_item;
      logic div_start;
      logic div_share;
      logic capture_mod;
      logic capture_share;
      logic emit;
      logic advance_ptr;
   } rrpa_cmd_type;

   typedef struct packed {
      logic users_zero;
      logic div_done;
      logic sched_zero;
      logic last_grant;
      logic out_free;
   } rrpa_status_type;

endpackage

// ----- rtl/rrpa_if.sv -----
// ----------------------------------------------------------------------------
// Round-robin PRB allocator channels
// Valid/ready channels for interval ticks and for the grants they produce.
// ----------------------------------------------------------------------------
interface rrpa_req_if import rrpa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TICK_WIDTH-1:0] interval_number;

   modport source (output valid, output interval_number, input ready);
   modport sink   (input valid, input interval_number, output ready);
endinterface

interface rrpa_rsp_if import rrpa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TICK_WIDTH-1:0]   interval_echo;
   logic [SLOT_WIDTH-1:0]   user_slot;
   logic [START_WIDTH-1:0]  start_block;
   logic [LENGTH_WIDTH-1:0] grant_length;
   logic                    final_grant;

   modport source (output valid, output interval_echo, output user_slot,
                   output start_block, output grant_length, output final_grant,
                   input ready);
   modport sink   (input valid, input interval_echo, input user_slot,
                   input start_block, input grant_length, input final_grant,
                   output ready);
endinterface

// ----- rtl/rrpa_divider.sv -----
// ----------------------------------------------------------------------------
// Round-robin PRB allocator divider
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrpa_divider import rrpa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [BLOCK_WIDTH-1:0]  dividend,
   input  logic [USER_WIDTH-1:0]   divisor,
   output logic                    done,
   output logic [BLOCK_WIDTH-1:0]  quotient,
   output logic [USER_WIDTH-1:0]   remainder
);

   logic [USER_WIDTH-1:0]      rem_ff, rem_in;
   logic [BLOCK_WIDTH-1:0]     quo_ff, quo_in;
   logic [USER_WIDTH-1:0]      divisor_ff;
   logic [DIV_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [USER_WIDTH:0]        trial;
   logic [USER_WIDTH:0]        diff;

   assign trial = {rem_ff, quo_ff[BLOCK_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = diff[USER_WIDTH-1:0];
            quo_in = {quo_ff[BLOCK_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[USER_WIDTH-1:0];
            quo_in = {quo_ff[BLOCK_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_COUNT_WIDTH'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      count_ff <= count_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/rrpa_datapath.sv -----
// ----------------------------------------------------------------------------
// Round-robin PRB allocator datapath
// Configuration registers, rotation pointer, share arithmetic, grant
// counters and the output register of the grant channel.
// ----------------------------------------------------------------------------
module rrpa_datapath import rrpa_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic [TICK_WIDTH-1:0]      req_interval_number,
   input  rrpa_cmd_type               cmd,
   output rrpa_status_type            status,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [TICK_WIDTH-1:0]      rsp_interval_echo,
   output logic [SLOT_WIDTH-1:0]      rsp_user_slot,
   output logic [START_WIDTH-1:0]     rsp_start_block,
   output logic [LENGTH_WIDTH-1:0]    rsp_grant_length,
   output logic                       rsp_final_grant
);

   logic [USER_WIDTH-1:0]   user_count_ff;
   logic [BLOCK_WIDTH-1:0]  block_count_ff;
   logic [TICK_WIDTH-1:0]   tick_ff;
   logic [USER_WIDTH-1:0]   users_ff;
   logic [BLOCK_WIDTH-1:0]  blocks_ff;
   logic [SLOT_WIDTH-1:0]   ptr_ff, ptr_in;
   logic [BLOCK_WIDTH-1:0]  share_ff;
   logic [USER_WIDTH-1:0]   extra_ff;
   logic [USER_WIDTH-1:0]   sched_ff;
   logic [SLOT_WIDTH-1:0]   slot_ff, slot_in;
   logic [USER_WIDTH-1:0]   index_ff;
   logic [BLOCK_WIDTH-1:0]  start_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TICK_WIDTH-1:0]   rsp_echo_ff;
   logic [SLOT_WIDTH-1:0]   rsp_slot_ff;
   logic [START_WIDTH-1:0]  rsp_start_ff;
   logic [LENGTH_WIDTH-1:0] rsp_length_ff;
   logic                    rsp_final_ff;

   logic [BLOCK_WIDTH-1:0]  div_dividend;
   logic                    div_done;
   logic [BLOCK_WIDTH-1:0]  div_quotient;
   logic [USER_WIDTH-1:0]   div_remainder;
   logic [LENGTH_WIDTH-1:0] grant_len;
   logic                    grant_final;
   logic [USER_WIDTH-1:0]   sched_calc;
   logic [USER_WIDTH-1:0]   index_next;

   assign div_dividend = cmd.div_share ? blocks_ff : {{(BLOCK_WIDTH-SLOT_WIDTH){1'b0}}, ptr_ff};

   rrpa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (users_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign sched_calc  = ({{(BLOCK_WIDTH-USER_WIDTH){1'b0}}, users_ff} < blocks_ff)
                        ? users_ff : blocks_ff[USER_WIDTH-1:0];
   assign index_next  = index_ff + 1'b1;
   assign grant_len   = share_ff + {{(LENGTH_WIDTH-1){1'b0}}, (index_ff < extra_ff)};
   assign grant_final = (index_next == sched_ff);

   always_comb begin
      slot_in = slot_ff + 1'b1;
      if ({1'b0, slot_ff} == users_ff - 1'b1) begin
         slot_in = '0;
      end
      ptr_in = ptr_ff + 1'b1;
      if ({1'b0, ptr_ff} == users_ff - 1'b1) begin
         ptr_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         user_count_ff  <= '0;
         block_count_ff <= '0;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_USER_COUNT:  user_count_ff  <= csr_write_data[USER_WIDTH-1:0];
               CSR_BLOCK_COUNT: block_count_ff <= csr_write_data[BLOCK_WIDTH-1:0];
               default: ;
            endcase
         end
         if (cmd.capture_mod) begin
            ptr_ff <= div_remainder[SLOT_WIDTH-1:0];
         end else if (cmd.advance_ptr) begin
            ptr_ff <= ptr_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         tick_ff   <= req_interval_number;
         users_ff  <= (user_count_ff > MAX_USERS) ? MAX_USERS : user_count_ff;
         blocks_ff <= (block_count_ff > MAX_BLOCKS) ? MAX_BLOCKS : block_count_ff;
      end
      if (cmd.capture_share) begin
         share_ff <= div_quotient;
         extra_ff <= div_remainder;
         sched_ff <= sched_calc;
         slot_ff  <= ptr_ff;
         index_ff <= '0;
         start_ff <= '0;
      end else if (cmd.emit) begin
         slot_ff  <= slot_in;
         index_ff <= index_next;
         start_ff <= start_ff + grant_len;
      end
      if (cmd.emit) begin
         rsp_echo_ff   <= tick_ff;
         rsp_slot_ff   <= slot_ff;
         rsp_start_ff  <= start_ff[START_WIDTH-1:0];
         rsp_length_ff <= grant_len;
         rsp_final_ff  <= grant_final;
      end
   end

   assign status.users_zero = (users_ff == '0);
   assign status.div_done   = div_done;
   assign status.sched_zero = (sched_ff == '0);
   assign status.last_grant = grant_final;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_interval_echo = rsp_echo_ff;
   assign rsp_user_slot     = rsp_slot_ff;
   assign rsp_start_block   = rsp_start_ff;
   assign rsp_grant_length  = rsp_length_ff;
   assign rsp_final_grant   = rsp_final_ff;

   a_ptr_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.capture_mod |=> ({1'b0, ptr_ff} < users_ff))
      else $error("Rotation pointer not below the user count after reduction.");

   a_length_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (grant_len != '0))
      else $error("Grant of zero blocks issued.");

   a_within_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (({1'b0, start_ff} + {1'b0, grant_len}) <= {1'b0, blocks_ff}))
      else $error("Grant extends beyond the available blocks.");

   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> ({1'b0, slot_ff} < users_ff))
      else $error("Granted user slot outside the active users.");

endmodule

// ----- rtl/rrpa_controller.sv -----
// ----------------------------------------------------------------------------
// Round-robin PRB allocator controller
// Sequences pointer reduction, share division and grant emission.
// ----------------------------------------------------------------------------
module rrpa_controller import rrpa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rrpa_status_type status,
   output rrpa_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_CHECK      = 3'd1;
   localparam logic [2:0] ST_MOD_WAIT   = 3'd2;
   localparam logic [2:0] ST_SHARE_WAIT = 3'd3;
   localparam logic [2:0] ST_EMIT       = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.users_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_MOD_WAIT;
            end
         end
         ST_MOD_WAIT: begin
            if (status.div_done) begin
               cmd.capture_mod = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_share   = 1'b1;
               state_in        = ST_SHARE_WAIT;
            end
         end
         ST_SHARE_WAIT: begin
            if (status.div_done) begin
               cmd.capture_share = 1'b1;
               state_in          = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.sched_zero) begin
               cmd.advance_ptr = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_grant) begin
                  cmd.advance_ptr = 1'b1;
                  state_in        = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/round_robin_prb_allocator.sv -----
// ----------------------------------------------------------------------------
// Round-robin PRB allocator
// Splits the resource blocks of each scheduling interval among the active
// users in rotation order and issues one grant transaction per user.
// ----------------------------------------------------------------------------
// Each interval tick is taken as one transaction when the allocator is idle.
// The user count and block count are saturated to 64 and 512 when the tick
// is taken. A tick goes through setup, then through the shared bit-serial
// divider to reduce the rotation pointer, then through it again to form
// the share and remainder, and then issues one grant per cycle while the
// sink accepts them, min(users, blocks) grants in all. A tick with users
// but no blocks produces nothing. A tick with no users produces nothing
// and returns to idle.
// Grants leave through a registered output, so the last grant of one
// interval may wait for the sink while the next tick is already taken.
// ----------------------------------------------------------------------------
module round_robin_prb_allocator import rrpa_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   rrpa_req_if.sink                   req_if,
   rrpa_rsp_if.source                 rsp_if,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   rrpa_cmd_type    cmd;
   rrpa_status_type status;

   rrpa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrpa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_interval_number (req_if.interval_number),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_interval_echo   (rsp_if.interval_echo),
      .rsp_user_slot       (rsp_if.user_slot),
      .rsp_start_block     (rsp_if.start_block),
      .rsp_grant_length    (rsp_if.grant_length),
      .rsp_final_grant     (rsp_if.final_grant)
   );

endmodule
